// ===== hdl/m3a_pkg.sv =====
// Package for the 3x3 matrix arithmetic unit: widths, operation codes,
// index tables and the saturation helper. No dependencies.
`default_nettype none
package m3a_pkg;
	localparam int EW = 32;                  // element width
	localparam int FB = 16;                  // fraction bits
	localparam int ACC_W = 2 * EW + 3;       // exact sum of three products
	localparam int DVD_W = EW + FB;          // divider dividend width
	localparam int QUO_W = DVD_W + 1;        // signed quotient

	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_RUN    = 2'd2;

	localparam logic [3:0] OP_ADD  = 4'd0;
	localparam logic [3:0] OP_SUB  = 4'd1;
	localparam logic [3:0] OP_MUL  = 4'd2;
	localparam logic [3:0] OP_DET  = 4'd3;
	localparam logic [3:0] OP_INV  = 4'd4;
	localparam logic [3:0] OP_TRN  = 4'd5;
	localparam logic [3:0] OP_ADDS = 4'd6;
	localparam logic [3:0] OP_SUBS = 4'd7;
	localparam logic [3:0] OP_MULS = 4'd8;
	localparam logic [3:0] OP_DIVS = 4'd9;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_DZ  = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic signed [ACC_W-1:0] SAT_HI =
		ACC_W'((64'sd1 <<< (EW - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	typedef struct packed {
		logic signed [EW-1:0] val;
		logic                 ovf;
	} sat_t;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic [3:0] c;
		logic [3:0] d;
	} cof_t;

	function automatic sat_t sat_fn(input logic signed [ACC_W-1:0] x);
		sat_t r;
		if (x > SAT_HI) begin
			r.val = SAT_HI[EW-1:0];
			r.ovf = 1'b1;
		end else if (x < SAT_LO) begin
			r.val = SAT_LO[EW-1:0];
			r.ovf = 1'b1;
		end else begin
			r.val = x[EW-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	// first element of the row of i
	function automatic logic [3:0] row_fn(input logic [3:0] i);
		case (i)
			4'd0, 4'd1, 4'd2: row_fn = 4'd0;
			4'd3, 4'd4, 4'd5: row_fn = 4'd3;
			default:          row_fn = 4'd6;
		endcase
	endfunction

	function automatic logic [3:0] col_fn(input logic [3:0] i);
		case (i)
			4'd0, 4'd3, 4'd6: col_fn = 4'd0;
			4'd1, 4'd4, 4'd7: col_fn = 4'd1;
			default:          col_fn = 4'd2;
		endcase
	endfunction

	function automatic logic [3:0] trn_fn(input logic [3:0] i);
		case (i)
			4'd1:    trn_fn = 4'd3;
			4'd2:    trn_fn = 4'd6;
			4'd3:    trn_fn = 4'd1;
			4'd5:    trn_fn = 4'd7;
			4'd6:    trn_fn = 4'd2;
			4'd7:    trn_fn = 4'd5;
			default: trn_fn = i;
		endcase
	endfunction

	// adjugate element i = A[a]*A[b] - A[c]*A[d]
	function automatic cof_t cof_fn(input logic [3:0] i);
		case (i)
			4'd0:    cof_fn = '{4'd4, 4'd8, 4'd5, 4'd7};
			4'd1:    cof_fn = '{4'd2, 4'd7, 4'd1, 4'd8};
			4'd2:    cof_fn = '{4'd1, 4'd5, 4'd2, 4'd4};
			4'd3:    cof_fn = '{4'd5, 4'd6, 4'd3, 4'd8};
			4'd4:    cof_fn = '{4'd0, 4'd8, 4'd2, 4'd6};
			4'd5:    cof_fn = '{4'd2, 4'd3, 4'd0, 4'd5};
			4'd6:    cof_fn = '{4'd3, 4'd7, 4'd4, 4'd6};
			4'd7:    cof_fn = '{4'd1, 4'd6, 4'd0, 4'd7};
			default: cof_fn = '{4'd0, 4'd4, 4'd1, 4'd3};
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== hdl/m3a_in_if.sv =====
// Request channel of the 3x3 matrix unit: valid/ready plus request payload.
// Depends on m3a_pkg.
`default_nettype none
interface m3a_in_if import m3a_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [3:0]           elem_index;
	logic signed [EW-1:0] value;
	logic [3:0]           op_code;
	logic                 write_back;

	modport source (output valid, req_type, elem_index, value, op_code, write_back,
		input ready);
	modport sink (input valid, req_type, elem_index, value, op_code, write_back,
		output ready);
endinterface
`default_nettype wire

// ===== hdl/m3a_out_if.sv =====
// Result channel of the 3x3 matrix unit: valid/ready plus result payload.
// Depends on m3a_pkg.
`default_nettype none
interface m3a_out_if import m3a_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [3:0]           out_index;
	logic signed [EW-1:0] out_value;
	logic                 is_last;
	logic [1:0]           status;

	modport source (output valid, out_index, out_value, is_last, status, input ready);
	modport sink (input valid, out_index, out_value, is_last, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/m3a_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none
module m3a_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 9,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr0,
	input  wire logic [AW-1:0]    raddr1,
	output logic      [WIDTH-1:0] rdata0,
	output logic      [WIDTH-1:0] rdata1
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata0 <= mem_q[raddr0];
		rdata1 <= mem_q[raddr1];
	end
endmodule
`default_nettype wire

// ===== hdl/m3a_div.sv =====
// Restoring divider, one quotient bit per cycle: (num * 2^FB) / den,
// truncated toward zero. Depends on m3a_pkg.
`default_nettype none
module m3a_div import m3a_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [EW-1:0]    num,
	input  wire logic signed [EW-1:0]    den,
	output logic                         done,
	output logic signed [QUO_W-1:0]      quo
);
	localparam int CW = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [EW-1:0]    dvs_q;
	logic [EW-1:0]    rem_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [EW:0]      trial;
	logic             fit;
	logic [EW-1:0]    num_mag;
	logic [EW-1:0]    den_mag;

	assign num_mag = num[EW-1] ? EW'(-num) : EW'(num);
	assign den_mag = den[EW-1] ? EW'(-den) : EW'(den);
	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign fit     = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in where dividend bits leave
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DVD_W'(num_mag) << FB;
			dvs_q <= den_mag;
			rem_q <= '0;
			neg_q <= num[EW-1] ^ den[EW-1];
		end else if (busy_q) begin
			rem_q <= fit ? EW'(trial - {1'b0, dvs_q}) : trial[EW-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], fit};
		end
	end

	assign quo = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
endmodule
`default_nettype wire

// ===== hdl/matrix3x3_arith_unit.sv =====
// Top level of the 3x3 matrix arithmetic unit (Q16.16): element stores,
// sequencer, shared multiplier/accumulator. Uses m3a_pkg, m3a_in_if,
// m3a_out_if, m3a_ram and m3a_div.
//
//   channel   dir   modport  payload
//   in_ch     in    sink     req_type, elem_index, value, op_code, write_back
//   out_ch    out   source   out_index, out_value, is_last, status
//
// Loads are written to the element stores as they are accepted. A run reads,
// multiplies and accumulates each product term (S_RD, S_EX, S_AC) and finishes
// each element in S_FIN on the single 32x32 multiplier; inverse and scalar divide
// also pass each element through the bit-serial divider (48 quotient bits). Each
// result then goes through S_ORD, S_OLD and S_OWT, where output stalls hold it. in_ch.ready is high only while idle.
// Reset clears control only; matrix contents are undefined until loaded.
`default_nettype none
module matrix3x3_arith_unit import m3a_pkg::*; (
	input wire logic   clk,
	input wire logic   arst_n,
	m3a_in_if.sink     in_ch,
	m3a_out_if.source  out_ch
);
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_EX   = 4'd2;
	localparam logic [3:0] S_AC   = 4'd3;
	localparam logic [3:0] S_FIN  = 4'd4;
	localparam logic [3:0] S_DVWT = 4'd5;
	localparam logic [3:0] S_ORD  = 4'd6;
	localparam logic [3:0] S_OLD  = 4'd7;
	localparam logic [3:0] S_OWT  = 4'd8;

	localparam logic [1:0] PH_MAIN = 2'd0;
	localparam logic [1:0] PH_COF  = 2'd1;
	localparam logic [1:0] PH_DET  = 2'd2;
	localparam logic [1:0] PH_DIV  = 2'd3;

	localparam logic [2:0] Y_ZERO = 3'd0;
	localparam logic [2:0] Y_B    = 3'd1;
	localparam logic [2:0] Y_A1   = 3'd2;
	localparam logic [2:0] Y_ADJ  = 3'd3;
	localparam logic [2:0] Y_V    = 3'd4;

	logic [3:0]           state_q;
	logic [1:0]           phase_q;
	logic [3:0]           op_q;
	logic                 wb_q;
	logic                 dz_q;
	logic                 sat_q;
	logic [3:0]           i_q;
	logic [1:0]           k_q;
	logic signed [EW-1:0] v_q;
	logic signed [EW-1:0] det_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [2*EW-1:0]  prod_q;

	logic                 ovalid_q;
	logic [3:0]           oidx_q;
	logic signed [EW-1:0] oval_q;
	logic                 olast_q;
	logic [1:0]           ost_q;

	logic [3:0] ax, ay, bx, jx;
	logic [2:0] ysel;
	logic       mult, neg, last_term;
	cof_t       cf;

	logic [EW-1:0] a_rd0, a_rd1, b_rd, adj_rd, res_rd;
	logic          a_we;
	logic [3:0]    a_waddr;
	logic [EW-1:0] a_wdata;
	logic          b_we, adj_we, res_we;
	logic [3:0]    res_waddr;
	logic [EW-1:0] res_wdata;

	logic signed [EW-1:0]    xop, yop;
	logic signed [ACC_W-1:0] sum_in, acc_scaled;
	sat_t                    fin;
	logic                    div_start, div_done;
	logic signed [QUO_W-1:0] div_quo;
	logic [3:0]              n_last;
	logic                    in_xfer, out_xfer;
	logic [EW-1:0]           res_out;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign in_ch.ready = state_q == S_IDLE;
	assign n_last = (op_q == OP_DET) ? 4'd0 : 4'd8;

	// operand addressing per phase and operation
	always_comb begin
		ax = i_q;
		ay = i_q;
		bx = i_q;
		jx = i_q;
		ysel = Y_ZERO;
		mult = 1'b0;
		neg = 1'b0;
		last_term = 1'b1;
		cf = cof_fn(i_q);
		case (phase_q)
			PH_MAIN: begin
				case (op_q)
					OP_ADD: ysel = Y_B;
					OP_SUB: begin
						ysel = Y_B;
						neg = 1'b1;
					end
					OP_MUL: begin
						ax = row_fn(i_q) + {2'b0, k_q};
						bx = col_fn(i_q) + {2'b0, k_q} + {1'b0, k_q, 1'b0};
						ysel = Y_B;
						mult = 1'b1;
						last_term = k_q == 2'd2;
					end
					OP_TRN: ax = trn_fn(i_q);
					OP_ADDS: ysel = Y_V;
					OP_SUBS: begin
						ysel = Y_V;
						neg = 1'b1;
					end
					OP_MULS: begin
						ysel = Y_V;
						mult = 1'b1;
					end
					default: ysel = Y_ZERO;
				endcase
			end
			PH_COF: begin
				ax = k_q[0] ? cf.c : cf.a;
				ay = k_q[0] ? cf.d : cf.b;
				ysel = Y_A1;
				mult = 1'b1;
				neg = k_q[0];
				last_term = k_q[0];
			end
			PH_DET: begin
				ax = {2'b0, k_q};
				jx = {2'b0, k_q} + {1'b0, k_q, 1'b0};
				ysel = Y_ADJ;
				mult = 1'b1;
				last_term = k_q == 2'd2;
			end
			default: ysel = Y_ZERO;
		endcase
	end

	assign xop = $signed(a_rd0);
	always_comb begin
		case (ysel)
			Y_B:     yop = $signed(b_rd);
			Y_A1:    yop = $signed(a_rd1);
			Y_ADJ:   yop = $signed(adj_rd);
			Y_V:     yop = v_q;
			default: yop = '0;
		endcase
	end

	assign sum_in = neg ? -ACC_W'(prod_q) : ACC_W'(prod_q);
	assign acc_scaled = mult ? (acc_q >>> FB) : acc_q;
	assign fin = sat_fn(acc_scaled);

	assign div_start = (state_q == S_EX) && (phase_q == PH_DIV);

	m3a_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ((op_q == OP_INV) ? $signed(adj_rd) : xop),
		.den    ((op_q == OP_INV) ? det_q : v_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign res_out = dz_q ? '0 : res_rd;

	// A takes loads while idle and write-back while streaming results
	always_comb begin
		a_we = 1'b0;
		a_waddr = in_ch.elem_index;
		a_wdata = in_ch.value;
		if (state_q == S_IDLE) begin
			a_we = in_xfer && in_ch.req_type == REQ_LOAD_A && in_ch.elem_index < 4'd9;
		end else if (state_q == S_OLD) begin
			a_we = wb_q && op_q != OP_DET;
			a_waddr = i_q;
			a_wdata = res_out;
		end
	end
	assign b_we = in_xfer && in_ch.req_type == REQ_LOAD_B && in_ch.elem_index < 4'd9;

	assign adj_we = state_q == S_FIN && phase_q == PH_COF;
	assign res_we = state_q == S_FIN && (phase_q == PH_MAIN || phase_q == PH_DIV
		|| (phase_q == PH_DET && op_q == OP_DET));
	assign res_waddr = (phase_q == PH_DET) ? 4'd0 : i_q;
	assign res_wdata = fin.val;

	m3a_ram #(.WIDTH(EW), .DEPTH(9)) u_mat_a (
		.clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
		.raddr0(ax), .raddr1(ay), .rdata0(a_rd0), .rdata1(a_rd1)
	);
	m3a_ram #(.WIDTH(EW), .DEPTH(9)) u_mat_b (
		.clk(clk), .we(b_we), .waddr(in_ch.elem_index), .wdata(in_ch.value),
		.raddr0(bx), .raddr1(bx), .rdata0(b_rd), .rdata1()
	);
	m3a_ram #(.WIDTH(EW), .DEPTH(9)) u_adj (
		.clk(clk), .we(adj_we), .waddr(i_q), .wdata(fin.val),
		.raddr0(jx), .raddr1(jx), .rdata0(adj_rd), .rdata1()
	);
	m3a_ram #(.WIDTH(EW), .DEPTH(9)) u_res (
		.clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
		.raddr0(i_q), .raddr1(i_q), .rdata0(res_rd), .rdata1()
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= PH_MAIN;
			op_q     <= OP_ADD;
			wb_q     <= 1'b0;
			dz_q     <= 1'b0;
			sat_q    <= 1'b0;
			i_q      <= '0;
			k_q      <= '0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer && in_ch.req_type == REQ_RUN && in_ch.op_code <= OP_DIVS) begin
						op_q  <= in_ch.op_code;
						wb_q  <= in_ch.write_back;
						sat_q <= 1'b0;
						i_q   <= '0;
						k_q   <= '0;
						dz_q  <= 1'b0;
						if (in_ch.op_code == OP_DIVS && in_ch.value == '0) begin
							dz_q    <= 1'b1;
							state_q <= S_ORD;
						end else begin
							state_q <= S_RD;
							if (in_ch.op_code == OP_DET || in_ch.op_code == OP_INV)
								phase_q <= PH_COF;
							else if (in_ch.op_code == OP_DIVS)
								phase_q <= PH_DIV;
							else
								phase_q <= PH_MAIN;
						end
					end
				end
				S_RD: state_q <= S_EX;
				S_EX: begin
					if (phase_q == PH_DIV)
						state_q <= S_DVWT;
					else if (mult)
						state_q <= S_AC;
					else
						state_q <= S_FIN;
				end
				S_AC: begin
					if (last_term) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_RD;
					end
				end
				S_DVWT: begin
					if (div_done)
						state_q <= S_FIN;
				end
				S_FIN: begin
					sat_q <= sat_q | fin.ovf;
					k_q   <= '0;
					if (phase_q == PH_DET) begin
						i_q <= '0;
						if (op_q == OP_DET) begin
							state_q <= S_ORD;
						end else if (fin.val == '0) begin
							dz_q    <= 1'b1;
							state_q <= S_ORD;
						end else begin
							phase_q <= PH_DIV;
							state_q <= S_RD;
						end
					end else if (i_q == 4'd8) begin
						i_q <= '0;
						if (phase_q == PH_COF) begin
							phase_q <= PH_DET;
							state_q <= S_RD;
						end else begin
							state_q <= S_ORD;
						end
					end else begin
						i_q     <= i_q + 4'd1;
						state_q <= S_RD;
					end
				end
				S_ORD: state_q <= S_OLD;
				S_OLD: begin
					ovalid_q <= 1'b1;
					state_q  <= S_OWT;
				end
				S_OWT: begin
					if (out_xfer) begin
						ovalid_q <= 1'b0;
						if (i_q == n_last) begin
							state_q <= S_IDLE;
						end else begin
							i_q     <= i_q + 4'd1;
							state_q <= S_ORD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath: shared multiplier, accumulator, scalar and determinant
	always_ff @(posedge clk) begin
		if (in_xfer)
			v_q <= in_ch.value;
		if (state_q == S_EX) begin
			if (mult)
				prod_q <= xop * yop;
			else
				acc_q <= ACC_W'(xop) + (neg ? -ACC_W'(yop) : ACC_W'(yop));
		end else if (state_q == S_AC) begin
			acc_q <= acc_q + sum_in;
		end else if (state_q == S_DVWT) begin
			acc_q <= ACC_W'(div_quo);
		end else if (state_q == S_FIN || state_q == S_IDLE) begin
			acc_q <= '0;
		end
		if (state_q == S_FIN && phase_q == PH_DET)
			det_q <= fin.val;
		if (state_q == S_OLD) begin
			oidx_q  <= i_q;
			oval_q  <= res_out;
			olast_q <= i_q == n_last;
			ost_q   <= dz_q ? ST_DZ : (sat_q ? ST_SAT : ST_OK);
		end
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.out_index = oidx_q;
	assign out_ch.out_value = oval_q;
	assign out_ch.is_last   = olast_q;
	assign out_ch.status    = ost_q;
endmodule
`default_nettype wire

// ===== tb/matrix3x3_arith_unit_tb.sv =====
// Testbench for matrix3x3_arith_unit: loads A/B, runs every operation with
// random stalls, predicts all result elements and checks them in order.
// Depends on m3a_pkg, m3a_in_if, m3a_out_if and the RTL of the block.
`timescale 1ns / 100ps
`default_nettype none
module matrix3x3_arith_unit_tb;
	import m3a_pkg::*;

	localparam logic [1:0] REQ_NONE = 2'd3;
	localparam int WDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES = 200;

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic [1:0] req;
		logic [3:0] idx;
		elem_t      val;
		logic [3:0] op;
		logic       wb;
	} req_item_t;

	typedef struct {
		logic [3:0] idx;
		elem_t      val;
		logic       last;
		logic [1:0] st;
	} elem_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	m3a_in_if  in_ch ();
	m3a_out_if out_ch ();

	matrix3x3_arith_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	always #5 clk = ~clk;

	req_item_t pending_reqs[$];
	elem_res_t expected_elems[$];
	elem_t     mat_a[9];
	elem_t     mat_b[9];
	int        mismatches = 0;
	int        total_reqs = 0;
	int        sent_reqs = 0;
	int        idle_cycles = 0;
	bit        quiet;

	assign quiet = (sent_reqs * 6 > total_reqs * 5);

	task automatic report(input string what, input int got, input int want);
		$display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic wide_t wide(input elem_t v);
		wide_t w;
		w = v;
		return w;
	endfunction

	function automatic elem_t sat(input wide_t x, inout bit ovf);
		wide_t hi, lo;
		hi = (wide_t'(1) <<< (EW - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			ovf = 1'b1;
			return hi[EW-1:0];
		end
		if (x < lo) begin
			ovf = 1'b1;
			return lo[EW-1:0];
		end
		return x[EW-1:0];
	endfunction

	// floor scaling by 2^-FB, then saturation
	function automatic elem_t scale(input wide_t x, inout bit ovf);
		return sat(x >>> FB, ovf);
	endfunction

	function automatic elem_t qdiv(input elem_t num, input elem_t den, inout bit ovf);
		return sat((wide(num) <<< FB) / wide(den), ovf);
	endfunction

	task automatic predict_run(input req_item_t it);
		elem_t res[9];
		elem_t adj[9];
		elem_t det;
		cof_t  cf;
		int    n, r, c;
		bit    ovf, dz;
		logic [1:0] st;
		n = 9;
		ovf = 0;
		dz = 0;
		for (int i = 0; i < 9; i++) res[i] = '0;
		case (it.op)
			OP_ADD, OP_SUB:
				for (int i = 0; i < 9; i++)
					res[i] = sat(it.op == OP_ADD ? wide(mat_a[i]) + wide(mat_b[i])
						: wide(mat_a[i]) - wide(mat_b[i]), ovf);
			OP_MUL:
				for (int i = 0; i < 9; i++) begin
					r = (i / 3) * 3;
					c = i % 3;
					res[i] = scale(wide(mat_a[r]) * wide(mat_b[c])
						+ wide(mat_a[r+1]) * wide(mat_b[c+3])
						+ wide(mat_a[r+2]) * wide(mat_b[c+6]), ovf);
				end
			OP_DET, OP_INV: begin
				for (int i = 0; i < 9; i++) begin
					cf = cof_fn(4'(i));
					adj[i] = scale(wide(mat_a[cf.a]) * wide(mat_a[cf.b])
						- wide(mat_a[cf.c]) * wide(mat_a[cf.d]), ovf);
				end
				det = scale(wide(mat_a[0]) * wide(adj[0]) + wide(mat_a[1]) * wide(adj[3])
					+ wide(mat_a[2]) * wide(adj[6]), ovf);
				if (it.op == OP_DET) begin
					res[0] = det;
					n = 1;
				end else if (det == 0) begin
					dz = 1;
				end else begin
					for (int i = 0; i < 9; i++) res[i] = qdiv(adj[i], det, ovf);
				end
			end
			OP_TRN:
				for (int i = 0; i < 9; i++) res[i] = mat_a[(i % 3) * 3 + i / 3];
			OP_ADDS, OP_SUBS:
				for (int i = 0; i < 9; i++)
					res[i] = sat(it.op == OP_ADDS ? wide(mat_a[i]) + wide(it.val)
						: wide(mat_a[i]) - wide(it.val), ovf);
			OP_MULS:
				for (int i = 0; i < 9; i++) res[i] = scale(wide(mat_a[i]) * wide(it.val), ovf);
			default:
				if (it.val == 0) dz = 1;
				else for (int i = 0; i < 9; i++) res[i] = qdiv(mat_a[i], it.val, ovf);
		endcase
		st = ST_OK;
		if (dz) begin
			for (int i = 0; i < 9; i++) res[i] = '0;
			st = ST_DZ;
		end else if (ovf) begin
			st = ST_SAT;
		end
		if (it.wb && n == 9)
			for (int i = 0; i < 9; i++) mat_a[i] = res[i];
		for (int i = 0; i < n; i++)
			expected_elems.push_back('{4'(i), res[i], i == n - 1, st});
	endtask

	task automatic predict(input req_item_t it);
		if (it.req == REQ_LOAD_A || it.req == REQ_LOAD_B) begin
			if (it.idx < 9) begin
				if (it.req == REQ_LOAD_A) mat_a[it.idx] = it.val;
				else mat_b[it.idx] = it.val;
			end
		end else if (it.req == REQ_RUN && it.op <= OP_DIVS) begin
			predict_run(it);
		end
	endtask

	// request driver
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		req_item_t it;
		logic      nxt_valid;
		if (!arst_n) begin
			in_ch.valid      <= 1'b0;
			in_ch.req_type   <= REQ_NONE;
			in_ch.elem_index <= '0;
			in_ch.value      <= '0;
			in_ch.op_code    <= '0;
			in_ch.write_back <= 1'b0;
		end else begin
			nxt_valid = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				predict('{in_ch.req_type, in_ch.elem_index, in_ch.value,
					in_ch.op_code, in_ch.write_back});
				sent_reqs++;
				nxt_valid = 1'b0;
				if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 14);
			end
			if (!nxt_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (pending_reqs.size() > 0) begin
					it = pending_reqs.pop_front();
					in_ch.req_type   <= it.req;
					in_ch.elem_index <= it.idx;
					in_ch.value      <= it.val;
					in_ch.op_code    <= it.op;
					in_ch.write_back <= it.wb;
					nxt_valid = 1'b1;
				end
			end
			in_ch.valid <= nxt_valid;
		end
	end

	// result monitor and sink stalls
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		elem_res_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_elems.size() == 0) begin
					report("unexpected result, index", out_ch.out_index, -1);
				end else begin
					e = expected_elems.pop_front();
					if (out_ch.out_index !== e.idx) report("out_index", out_ch.out_index, e.idx);
					if (out_ch.out_value !== e.val) report("out_value", out_ch.out_value, e.val);
					if (out_ch.is_last !== e.last) report("is_last", out_ch.is_last, e.last);
					if (out_ch.status !== e.st) report("status", out_ch.status, e.st);
				end
			end
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 14);
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 19))
			0, 1:  return 32'sh7FFF_FFFF;
			2, 3:  return 32'sh8000_0000;
			4:     return 32'sh0001_0000;
			5:     return -32'sh0001_0000;
			6:     return '0;
			7, 8:  return $urandom();
			9, 10: return elem_t'($urandom_range(0, 32'hFFFF)) - 32'sh8000;
			default: return elem_t'($urandom_range(0, 32'h8_0000)) - 32'sh4_0000;
		endcase
	endfunction

	task automatic add_load(input logic [1:0] req, input int idx, input elem_t v);
		pending_reqs.push_back('{req, 4'(idx), v, 4'($urandom_range(0, 15)), 1'($urandom())});
	endtask

	task automatic add_run(input logic [3:0] op, input elem_t v, input logic wb);
		pending_reqs.push_back('{REQ_RUN, 4'($urandom_range(0, 15)), v, op, wb});
	endtask

	initial begin
		int    runs;
		elem_t row[3];

		// directed: a well-conditioned A, then every operation
		for (int i = 0; i < 9; i++) begin
			add_load(REQ_LOAD_A, i, (i % 4 == 0) ? 32'sh0002_0000 : 32'sh0000_8000 * (i - 4));
			add_load(REQ_LOAD_B, i, 32'sh0001_8000 - 32'sh0000_4000 * i);
		end
		for (int op = 0; op <= 9; op++) add_run(4'(op), 32'sh0002_0000, 1'b0);
		add_load(REQ_LOAD_A, 12, 32'sh7FFF_FFFF);            // out-of-range index
		pending_reqs.push_back('{REQ_NONE, 4'd15, -1, OP_MUL, 1'b1});
		add_run(4'd12, 32'sh0001_0000, 1'b1);                 // unknown operation
		add_run(OP_DET, 32'sh0001_0000, 1'b1);                // write-back ignored
		add_run(OP_DIVS, '0, 1'b0);                           // scalar divide by zero
		add_load(REQ_LOAD_A, 0, 32'sh7FFF_FFFF);
		add_load(REQ_LOAD_A, 8, 32'sh8000_0000);
		add_run(OP_ADD, '0, 1'b0);
		add_run(OP_MUL, '0, 1'b0);
		add_run(OP_MULS, 32'sh8000_0000, 1'b0);
		add_run(OP_INV, '0, 1'b0);
		add_run(OP_DIVS, '0, 1'b1);                           // zeros stored into A
		add_run(OP_INV, '0, 1'b0);                            // singular A

		// random: load bursts followed by a run, some noise
		runs = 0;
		while (pending_reqs.size() < 210) begin
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1))
					pending_reqs.push_back('{REQ_NONE, 4'($urandom()), $urandom(),
						4'($urandom()), 1'($urandom())});
				else
					add_run(4'($urandom_range(OP_DIVS + 1, 15)), $urandom(), 1'($urandom()));
				continue;
			end
			if ($urandom_range(0, 7) == 0) begin
				// singular A: row 2 copies row 0
				for (int c = 0; c < 3; c++) begin
					row[c] = rand_elem();
					add_load(REQ_LOAD_A, c, row[c]);
					add_load(REQ_LOAD_A, 6 + c, row[c]);
				end
			end else begin
				repeat ($urandom_range(0, 6))
					add_load($urandom_range(0, 1) ? REQ_LOAD_A : REQ_LOAD_B,
						($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
						: $urandom_range(0, 8), rand_elem());
			end
			add_run(4'($urandom_range(0, OP_DIVS)),
				($urandom_range(0, 7) == 0) ? elem_t'(0) : rand_elem(),
				$urandom_range(0, 4) == 0);
			runs++;
		end
		total_reqs = pending_reqs.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_reqs.size() == 0 && sent_reqs == total_reqs
			&& expected_elems.size() == 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_elems.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/m3a_pkg.sv
hdl/m3a_in_if.sv
hdl/m3a_out_if.sv
hdl/m3a_ram.sv
hdl/m3a_div.sv
hdl/matrix3x3_arith_unit.sv
tb/matrix3x3_arith_unit_tb.sv
